### sv/sqe_pkg.sv
package sqe_pkg;

   // Sequencer states of the expander.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NORM_V,
      ST_SQ_TX,
      ST_SQ_TZ,
      ST_SQ_TY,
      ST_MUL_V1,
      ST_MUL_V2,
      ST_CMP_V,
      ST_NORM_H,
      ST_SQ_HX,
      ST_SQ_HZ,
      ST_SQ_SUM,
      ST_SQRT,
      ST_MUL_N,
      ST_DIV_LOAD,
      ST_DIV,
      ST_EMIT
   } sqe_state_type;

   localparam logic        KIND_VERTEX   = 1'b0;
   localparam logic        KIND_TRIANGLE = 1'b1;
   localparam logic [30:0] K_DY_WEIGHT   = 31'd9975;
   localparam logic [30:0] K_DH_WEIGHT   = 31'd990025;
   localparam logic [2:0]  BEAT_TRI_A    = 3'd4;
   localparam logic [2:0]  BEAT_LAST     = 3'd5;

   // Clamp a 34-bit signed sum into the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### sv/segment_to_quad_expander.sv
// Channel  | Direction | Handshake             | Payload
// req_     | in        | req_valid / req_ready | segment start, end, width, last flag
// rsp_     | out       | rsp_valid / rsp_ready | four vertices then two triangles
//
// One segment is taken at a time. A vertical or zero-length segment offers its
// first result beat after the pre-shift of the difference and the multiplier
// steps. Any other segment also passes the normalising shifts, the 32-step
// square root and two 32-step divisions, all run one step a cycle. Six result
// beats follow, each held until taken, so a stalled consumer simply stretches
// the run.
// Reset is synchronous and active high; it returns the sequencer to idle and
// clears the vertex counter.
module segment_to_quad_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_start_z,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   input  logic [31:0] req_end_z,
   input  logic [30:0] req_line_width,
   input  logic        req_last_segment,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic [15:0] rsp_index_a,
   output logic [15:0] rsp_index_b,
   output logic [15:0] rsp_index_c,
   output logic        rsp_last_of_run
);
   import sqe_pkg::*;

   sqe_state_type state_ff, state_in;

   // Captured segment.
   logic [31:0] start_x_ff, start_y_ff, start_z_ff, end_x_ff, end_y_ff, end_z_ff;
   logic [31:0] start_x_in, start_y_in, start_z_in, end_x_in, end_y_in, end_z_in;
   logic [30:0] width_ff, width_in;
   logic        last_ff, last_in;
   logic        dx_neg_ff, dx_neg_in, dz_pos_ff, dz_pos_in;

   // Magnitudes of the difference and their working (shifted) copies.
   logic [32:0] ax_ff, ax_in, az_ff, az_in;
   logic [32:0] tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;

   // Shared multiplier with its registered product, plus an accumulator.
   logic [40:0] op_a;
   logic [30:0] op_b;
   logic [71:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;

   // Square root and divider working registers.
   logic [62:0] rem_ff, rem_in, root_ff, root_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        pass_ff, pass_in;

   logic signed [32:0] off_x_ff, off_x_in, off_z_ff, off_z_in;
   logic [2:0]  beat_ff, beat_in;
   logic [15:0] vcount_ff, vcount_in;

   // Helpers.
   logic signed [32:0] dx_c, dy_c, dz_c;
   logic [32:0] or_v, or_h;
   logic [41:0] hsum;
   logic [62:0] sq_bit, sq_trial;
   logic [63:0] nsum;
   logic [32:0] dvs, dtrial;
   logic        dge;
   logic [31:0] quo_next;
   logic signed [32:0] q_ext;

   assign dx_c = {req_start_x[31], req_start_x} - {req_end_x[31], req_end_x};
   assign dy_c = {req_start_y[31], req_start_y} - {req_end_y[31], req_end_y};
   assign dz_c = {req_start_z[31], req_start_z} - {req_end_z[31], req_end_z};
   assign or_v = tx_ff | ty_ff | tz_ff;
   assign or_h = tx_ff | tz_ff;
   assign hsum = {1'b0, acc_ff[40:0]} + {1'b0, prod_ff[40:0]};
   assign sq_bit = 63'(1) << {cnt_ff, 1'b0};
   assign sq_trial = root_ff + sq_bit;
   assign nsum = prod_ff[63:0] + {32'd0, root_ff[31:0]};
   assign dvs = {root_ff[31:0], 1'b0};
   assign dtrial = {rem_ff[31:0], quo_ff[31]};
   assign dge = (dtrial >= dvs);
   assign quo_next = {quo_ff[30:0], dge};
   assign q_ext = {1'b0, quo_next};

   assign prod_in = 72'(op_a) * 72'(op_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= 16'd0;
         beat_ff   <= 3'd0;
         pass_ff   <= 1'b0;
         cnt_ff    <= 5'd0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         beat_ff   <= beat_in;
         pass_ff   <= pass_in;
         cnt_ff    <= cnt_in;
      end
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      start_z_ff <= start_z_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
      end_z_ff   <= end_z_in;
      width_ff   <= width_in;
      last_ff    <= last_in;
      dx_neg_ff  <= dx_neg_in;
      dz_pos_ff  <= dz_pos_in;
      ax_ff      <= ax_in;
      az_ff      <= az_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      tz_ff      <= tz_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      quo_ff     <= quo_in;
      off_x_ff   <= off_x_in;
      off_z_ff   <= off_z_in;
   end

   // Sequencer: each state captures the segment, shifts, drives the shared
   // multiplier, runs one step of the root or the divider, or emits a result beat.
   always_comb begin
      state_in   = state_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      start_z_in = start_z_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      end_z_in   = end_z_ff;
      width_in   = width_ff;
      last_in    = last_ff;
      dx_neg_in  = dx_neg_ff;
      dz_pos_in  = dz_pos_ff;
      ax_in      = ax_ff;
      az_in      = az_ff;
      tx_in      = tx_ff;
      ty_in      = ty_ff;
      tz_in      = tz_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      off_x_in   = off_x_ff;
      off_z_in   = off_z_ff;
      beat_in    = beat_ff;
      vcount_in  = vcount_ff;
      op_a       = 41'(tx_ff);
      op_b       = 31'(tx_ff);
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start_x_in = req_start_x;
               start_y_in = req_start_y;
               start_z_in = req_start_z;
               end_x_in   = req_end_x;
               end_y_in   = req_end_y;
               end_z_in   = req_end_z;
               width_in   = req_line_width;
               last_in    = req_last_segment;
               dx_neg_in  = dx_c[32];
               dz_pos_in  = !dz_c[32] && (dz_c != 33'sd0);
               ax_in      = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
               az_in      = dz_c[32] ? 33'(-dz_c) : 33'(dz_c);
               tx_in      = ax_in;
               ty_in      = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
               tz_in      = az_in;
               state_in   = ST_NORM_V;
            end
         end
         ST_NORM_V: begin
            if (or_v[32:20] != 13'd0) begin
               tx_in = tx_ff >> 1;
               ty_in = ty_ff >> 1;
               tz_in = tz_ff >> 1;
            end else begin
               state_in = ST_SQ_TX;
            end
         end
         ST_SQ_TX: begin
            op_a     = 41'(tx_ff);
            op_b     = 31'(tx_ff);
            state_in = ST_SQ_TZ;
         end
         ST_SQ_TZ: begin
            op_a     = 41'(tz_ff);
            op_b     = 31'(tz_ff);
            acc_in   = prod_ff[63:0];
            state_in = ST_SQ_TY;
         end
         ST_SQ_TY: begin
            op_a     = 41'(ty_ff);
            op_b     = 31'(ty_ff);
            acc_in   = acc_ff + prod_ff[63:0];
            state_in = ST_MUL_V1;
         end
         ST_MUL_V1: begin
            op_a     = prod_ff[40:0];
            op_b     = K_DY_WEIGHT;
            state_in = ST_MUL_V2;
         end
         ST_MUL_V2: begin
            op_a     = acc_ff[40:0];
            op_b     = K_DH_WEIGHT;
            acc_in   = prod_ff[63:0];
            state_in = ST_CMP_V;
         end
         ST_CMP_V: begin
            if (acc_ff > prod_ff[63:0]) begin
               off_x_in = $signed({1'b0, 32'({1'b0, width_ff} + 32'd1) >> 1});
               off_z_in = 33'sd0;
               beat_in  = 3'd0;
               state_in = ST_EMIT;
            end else if ((ax_ff | az_ff) == 33'd0) begin
               off_x_in = 33'sd0;
               off_z_in = 33'sd0;
               beat_in  = 3'd0;
               state_in = ST_EMIT;
            end else begin
               tx_in    = ax_ff;
               tz_in    = az_ff;
               state_in = ST_NORM_H;
            end
         end
         ST_NORM_H: begin
            if (or_h[32:20] != 13'd0) begin
               tx_in = tx_ff >> 1;
               tz_in = tz_ff >> 1;
            end else if (!or_h[19]) begin
               tx_in = tx_ff << 1;
               tz_in = tz_ff << 1;
            end else begin
               state_in = ST_SQ_HX;
            end
         end
         ST_SQ_HX: begin
            op_a     = 41'(tx_ff);
            op_b     = 31'(tx_ff);
            state_in = ST_SQ_HZ;
         end
         ST_SQ_HZ: begin
            op_a     = 41'(tz_ff);
            op_b     = 31'(tz_ff);
            acc_in   = prod_ff[63:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            rem_in   = 63'({hsum, 20'd0});
            root_in  = 63'd0;
            cnt_in   = 5'd31;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (rem_ff >= sq_trial) begin
               rem_in  = rem_ff - sq_trial;
               root_in = (root_ff >> 1) + sq_bit;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff == 5'd0) begin
               pass_in  = 1'b0;
               state_in = ST_MUL_N;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_MUL_N: begin
            op_a     = pass_ff ? 41'({tx_ff[19:0], 10'd0}) : 41'({tz_ff[19:0], 10'd0});
            op_b     = width_ff;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            rem_in   = 63'(nsum[63:32]);
            quo_in   = nsum[31:0];
            cnt_in   = 5'd31;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = dge ? 63'(dtrial - dvs) : 63'(dtrial);
            quo_in = quo_next;
            if (cnt_ff == 5'd0) begin
               if (!pass_ff) begin
                  off_x_in = dz_pos_ff ? -q_ext : q_ext;
                  pass_in  = 1'b1;
                  state_in = ST_MUL_N;
               end else begin
                  off_z_in = dx_neg_ff ? -q_ext : q_ext;
                  beat_in  = 3'd0;
                  state_in = ST_EMIT;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (beat_ff == BEAT_LAST) begin
                  vcount_in = last_ff ? 16'd0 : vcount_ff + 16'd4;
                  state_in  = ST_IDLE;
               end else begin
                  beat_in = beat_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat: vertices are start/end plus or minus the side offset,
   // triangles carry three consecutive vertex numbers.
   logic signed [33:0] base_x, base_z, sum_x, sum_z;
   logic [31:0] base_y;
   logic        is_tri;

   always_comb begin
      is_tri = (beat_ff >= BEAT_TRI_A);
      base_x = beat_ff[0] ? 34'(signed'(end_x_ff)) : 34'(signed'(start_x_ff));
      base_z = beat_ff[0] ? 34'(signed'(end_z_ff)) : 34'(signed'(start_z_ff));
      base_y = beat_ff[0] ? end_y_ff : start_y_ff;
      if (beat_ff[1]) begin
         sum_x = base_x - 34'(off_x_ff);
         sum_z = base_z - 34'(off_z_ff);
      end else begin
         sum_x = base_x + 34'(off_x_ff);
         sum_z = base_z + 34'(off_z_ff);
      end
      rsp_item_kind   = is_tri ? KIND_TRIANGLE : KIND_VERTEX;
      rsp_last_of_run = (beat_ff == BEAT_LAST);
      if (is_tri) begin
         rsp_pos_x   = 32'd0;
         rsp_pos_y   = 32'd0;
         rsp_pos_z   = 32'd0;
         rsp_index_a = (beat_ff == BEAT_TRI_A) ? vcount_ff : vcount_ff + 16'd1;
         rsp_index_b = rsp_index_a + 16'd1;
         rsp_index_c = rsp_index_a + 16'd2;
      end else begin
         rsp_pos_x   = sat32(sum_x);
         rsp_pos_y   = base_y;
         rsp_pos_z   = sat32(sum_z);
         rsp_index_a = vcount_ff + 16'(beat_ff);
         rsp_index_b = 16'd0;
         rsp_index_c = 16'd0;
      end
   end

endmodule

### sv/sqe_checker.sv
module sqe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_item_kind,
   input logic [31:0] rsp_pos_x,
   input logic [15:0] rsp_index_a,
   input logic [15:0] rsp_index_b,
   input logic [15:0] rsp_index_c,
   input logic        rsp_last_of_run
);
   import sqe_pkg::*;

   // A segment is never taken while results are still being offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("segment accepted while results pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again straight after a segment");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> !rsp_valid)
      else $error("results continue after the last beat");

   a_tri_indices: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == KIND_TRIANGLE) |->
         (rsp_index_b == rsp_index_a + 16'd1 && rsp_index_c == rsp_index_a + 16'd2))
      else $error("triangle corners not consecutive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pos_x)))
      else $error("stalled result beat changed");

endmodule

bind segment_to_quad_expander sqe_checker u_sqe_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item_kind(rsp_item_kind),
   .rsp_pos_x(rsp_pos_x),
   .rsp_index_a(rsp_index_a),
   .rsp_index_b(rsp_index_b),
   .rsp_index_c(rsp_index_c),
   .rsp_last_of_run(rsp_last_of_run)
);
